// File: rtl/sem_pkg.sv
// Package with shared types and constants for the Sobel edge block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int CfgWidthBits = 11;
    localparam int CfgHeightBits = 16;
    localparam logic [CfgWidthBits-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [CfgHeightBits-1:0] FRAME_HEIGHT_RESET = 16'd480;
    localparam logic CFG_IDX_WIDTH = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;
    localparam logic [7:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic load;      // latch a new input beat into the datapath
        logic emit_b;    // present the shifted (row end) result
    } sem_cmd_t;

    typedef struct packed {
        logic need_a;
        logic need_b;
        logic b_flast;
        logic mag_done;
    } sem_stat_t;
endpackage
`default_nettype wire

// File: rtl/sem_if.sv
// Valid/ready channel interfaces for pixel, edge and configuration beats.
`timescale 1ns / 1ps
`default_nettype none
interface sem_pix_if;
    logic valid;
    logic ready;
    logic mode;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    modport source(output valid, mode, pixel_red, pixel_green, pixel_blue, input ready);
    modport sink(input valid, mode, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface sem_edge_if;
    logic valid;
    logic ready;
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic row_last;
    logic frame_last;
    modport source(output valid, edge_red, edge_green, edge_blue, row_last, frame_last,
        input ready);
    modport sink(input valid, edge_red, edge_green, edge_blue, row_last, frame_last,
        output ready);
endinterface

interface sem_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/sem_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: rtl/sem_datapath.sv
// Datapath: line buffers, window, counters, Sobel sums and the magnitude search.
`timescale 1ns / 1ps
`default_nettype none
module sem_datapath #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [10:0]         frame_width,
    input  wire logic [15:0]         frame_height,
    input  wire sem_pkg::sem_cmd_t   cmd,
    input  wire logic                in_mode,
    input  wire logic [23:0]         in_pix,
    input  wire logic                rd_phase,
    input  wire logic                mag_start,
    output sem_pkg::sem_stat_t       stat,
    output logic                     ignore_beat,
    output logic [23:0]              mag_out,
    output logic                     row_last
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;
    localparam logic [7:0] MAG_MAX_L = sem_pkg::MAG_MAX;

    logic [AW-1:0] col_reg, dcnt_reg, col_next;
    logic [15:0]   row_reg;
    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;
    logic          drain;
    logic [AW-1:0] col_sel;
    logic [23:0]   prev_rd, curr_rd;
    logic [23:0]   win_reg [9];
    logic [23:0]   pix_reg;
    logic          drain_reg, last_reg, rr1_reg, rr2_reg, col0_reg;
    logic          shift_reg;
    logic          s_load_reg;
    logic [7:0]    n_reg;
    logic [2:0][16:0] s_reg;
    logic [2:0][7:0]  res_reg;

    always_comb
    begin
        if (frame_width == '0)
            w_eff = WW'(1);
        else if (int'(frame_width) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width);
        h_eff = (frame_height == '0) ? 16'd1 : frame_height;
        drain = row_reg >= h_eff;
        col_sel = drain ? dcnt_reg : col_reg;
        ignore_beat = !drain && in_mode;
    end

    // Buffers are read during the accept cycle and written on the following one.
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_prev (
        .clk(clk), .we(rd_phase && !drain_reg), .addr(col_sel),
        .wdata(curr_rd), .rdata(prev_rd));
    sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_curr (
        .clk(clk), .we(rd_phase && !drain_reg), .addr(col_sel),
        .wdata(pix_reg), .rdata(curr_rd));

    logic last_now;
    always_comb
    begin
        last_now = ({1'b0, col_sel} + WW'(1)) >= w_eff;
        col_next = last_now ? '0 : col_sel + AW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            dcnt_reg <= '0;
            row_reg  <= '0;
        end
        else if (rd_phase)
        begin
            if (drain_reg)
            begin
                dcnt_reg <= col_next;
                if (last_reg)
                begin
                    row_reg <= 16'd0;
                    col_reg <= '0;
                end
            end
            else
            begin
                col_reg <= col_next;
                if (last_reg)
                    row_reg <= row_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg   <= drain ? 24'd0 : in_pix;
            drain_reg <= drain;
            last_reg  <= last_now;
            rr1_reg   <= drain || row_reg >= 16'd1;
            rr2_reg   <= drain ? (h_eff >= 16'd2) : (row_reg >= 16'd2);
            col0_reg  <= col_sel == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (rd_phase)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= col0_reg ? 24'd0 : win_reg[r*3+1];
                win_reg[r*3+1] <= col0_reg ? 24'd0 : win_reg[r*3+2];
            end
            win_reg[2] <= rr2_reg ? prev_rd : 24'd0;
            win_reg[5] <= rr1_reg ? curr_rd : 24'd0;
            win_reg[8] <= pix_reg;
        end
    end

    // Sum of squares for one window alignment, saturated above the largest useful value.
    logic [2:0][16:0] s_calc;
    always_comb
    begin
        logic [23:0] a [9];
        logic signed [11:0] gx, gy;
        logic signed [23:0] sq;
        for (int r = 0; r < 3; r++)
        begin
            a[r*3]   = shift_reg ? win_reg[r*3+1] : win_reg[r*3];
            a[r*3+1] = shift_reg ? win_reg[r*3+2] : win_reg[r*3+1];
            a[r*3+2] = shift_reg ? 24'd0 : win_reg[r*3+2];
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            gx = 12'(a[2][ch*8+:8]) + 12'(a[5][ch*8+:8]) * 12'sd2 + 12'(a[8][ch*8+:8])
               - 12'(a[0][ch*8+:8]) - 12'(a[3][ch*8+:8]) * 12'sd2 - 12'(a[6][ch*8+:8]);
            gy = 12'(a[6][ch*8+:8]) + 12'(a[7][ch*8+:8]) * 12'sd2 + 12'(a[8][ch*8+:8])
               - 12'(a[0][ch*8+:8]) - 12'(a[1][ch*8+:8]) * 12'sd2 - 12'(a[2][ch*8+:8]);
            sq = 24'(gx * gx) + 24'(gy * gy);
            s_calc[ch] = (sq[23:17] != 7'd0) ? 17'h1FFFF : sq[16:0];
        end
    end

    // Result n is the largest n <= 255 with n*(n-1) < s; n steps up and the result takes n+1 while (n+1)*n < s.
    logic [2:0] grow;
    logic [16:0] nn;
    always_comb
    begin
        nn = 17'({9'd0, n_reg} * {9'd0, n_reg + 8'd1});
        for (int ch = 0; ch < 3; ch++)
            grow[ch] = (n_reg != MAG_MAX_L) && (nn < s_reg[ch]);
    end

    // The sums are registered in the cycle after the start, and the search steps after that.
    always_ff @(posedge clk)
    begin
        s_load_reg <= mag_start;
        if (mag_start)
        begin
            shift_reg <= cmd.emit_b;
            n_reg <= '0;
            res_reg <= '0;
        end
        else if (!s_load_reg && stat.mag_done == 1'b0)
        begin
            n_reg <= n_reg + 8'd1;
            for (int ch = 0; ch < 3; ch++)
                if (grow[ch])
                    res_reg[ch] <= n_reg + 8'd1;
        end
        if (s_load_reg)
            s_reg <= s_calc;
    end

    always_comb
    begin
        stat.need_a   = rr1_reg && !col0_reg;
        stat.need_b   = rr1_reg && last_reg;
        stat.b_flast  = drain_reg;
        stat.mag_done = n_reg == MAG_MAX_L;
        mag_out = {res_reg[2], res_reg[1], res_reg[0]};
        row_last = shift_reg;
    end
endmodule
`default_nettype wire

// File: rtl/sem_ctrl.sv
// Controller state machine sequencing accept, buffer update and result beats.
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               ignore_beat,
    input  wire logic               out_ready,
    input  wire sem_pkg::sem_stat_t stat,
    output logic                    in_ready,
    output sem_pkg::sem_cmd_t       cmd,
    output logic                    rd_phase,
    output logic                    mag_start,
    output logic                    out_valid,
    output logic                    frame_last
);
    typedef enum logic [2:0] {S_IDLE, S_UPD, S_CHK, S_SQ, S_RUN, S_OUT} state_t;
    state_t state_reg;
    logic   b_pend_reg, is_b_reg;

    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        cmd.load  = in_ready && in_valid && !ignore_beat;
        cmd.emit_b = (state_reg == S_CHK && !stat.need_a)
            || (state_reg == S_OUT && b_pend_reg);
        rd_phase  = state_reg == S_UPD;
        mag_start = (state_reg == S_CHK && (stat.need_a || b_pend_reg))
            || (state_reg == S_OUT && out_ready && b_pend_reg);
        out_valid = state_reg == S_OUT;
        frame_last = is_b_reg && stat.b_flast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            b_pend_reg <= 1'b0;
            is_b_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE: if (cmd.load) state_reg <= S_UPD;
                S_UPD:
                begin
                    b_pend_reg <= stat.need_b;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (stat.need_a && is_b_reg == 1'b0 && !(b_pend_reg && !stat.need_a))
                    begin
                        is_b_reg <= 1'b0;
                        state_reg <= S_SQ;
                    end
                    else if (b_pend_reg)
                    begin
                        is_b_reg <= 1'b1;
                        b_pend_reg <= 1'b0;
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        is_b_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_SQ: state_reg <= S_RUN;
                S_RUN: if (stat.mag_done) state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (b_pend_reg)
                        begin
                            is_b_reg <= 1'b1;
                            b_pend_reg <= 1'b0;
                            state_reg <= S_SQ;
                        end
                        else
                        begin
                            is_b_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("result beat while accepting input");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped");
    assert property (@(posedge clk) disable iff (!rst_n) rd_phase |-> $past(cmd.load))
        else $error("buffer update without accepted beat");
endmodule
`default_nettype wire

// File: rtl/sobel_edge_magnitude_rgb_top.sv
// Top level of the RGB Sobel edge magnitude block.
// A result beat is presented after its pixel beat is taken and the magnitude search has
// run; a second (row end) result follows, after another search, once the first is taken.
// A pixel beat gives no result, one or two, and output stalls add to its time; no new pixel
// is taken until it is done, and a drain beat ignored in pixel phase is taken and dropped.
// Reset clears counters, the window and sizes to 640 by 480; line buffers hold no reset.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    sem_pix_if.sink  pix,
    sem_edge_if.source edges,
    sem_cfg_if.sink  cfg
);
    logic [10:0] fw_reg;
    logic [15:0] fh_reg;
    sem_pkg::sem_cmd_t  cmd;
    sem_pkg::sem_stat_t stat;
    logic ignore_beat, rd_phase, mag_start, row_last;
    logic [23:0] mag;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= sem_pkg::FRAME_WIDTH_RESET;
            fh_reg <= sem_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == sem_pkg::CFG_IDX_WIDTH)
                fw_reg <= cfg.data[10:0];
            else
                fh_reg <= cfg.data;
        end
    end

    sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .frame_width(fw_reg), .frame_height(fh_reg),
        .cmd(cmd), .in_mode(pix.mode),
        .in_pix({pix.pixel_red, pix.pixel_green, pix.pixel_blue}),
        .rd_phase(rd_phase), .mag_start(mag_start), .stat(stat),
        .ignore_beat(ignore_beat), .mag_out(mag), .row_last(row_last));

    sem_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(pix.valid), .ignore_beat(ignore_beat),
        .out_ready(edges.ready), .stat(stat), .in_ready(pix.ready), .cmd(cmd),
        .rd_phase(rd_phase), .mag_start(mag_start), .out_valid(edges.valid),
        .frame_last(edges.frame_last));

    assign edges.edge_red   = mag[23:16];
    assign edges.edge_green = mag[15:8];
    assign edges.edge_blue  = mag[7:0];
    assign edges.row_last   = row_last;
endmodule
`default_nettype wire
